// ===== hw/rtl/url_canonical_encoder_core_macros.svh =====
// Assertion macros for the URL canonical encoder core.
// Used by the top level only; needs nothing else.
`ifndef URL_CANONICAL_ENCODER_CORE_MACROS_SVH
`define URL_CANONICAL_ENCODER_CORE_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define UCENC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent on one edge implies consequent on the same edge.
`define UCENC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ucenc_pkg.sv =====
// Package for the URL canonical encoder: types, codes, character-class functions.
// No dependencies.
`default_nettype none

package ucenc_pkg;

  localparam int unsigned QDepth   = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 3;

  localparam logic [7:0] Percent      = 8'h25;
  localparam logic [7:0] HexAlphaBase = 8'h37;  // 'A' - 10
  localparam logic [7:0] DigitBase    = 8'h30;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMode   = 1'b0,
    CfgDecode = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ModePath   = 3'd0,
    ModeSearch = 3'd1,
    ModeUser   = 3'd2,
    ModeFtp    = 3'd3,
    ModeParam  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhHigh = 2'd1,
    PhLow  = 2'd2
  } esc_phase_e;

  typedef enum logic [1:0] {
    CmdRaw = 2'd0,
    CmdEsc = 2'd1,
    CmdErr = 2'd2
  } cmd_kind_e;

  localparam logic [1:0] StepPct  = 2'd0;
  localparam logic [1:0] StepHigh = 2'd1;
  localparam logic [1:0] StepLow  = 2'd2;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  function automatic logic is_alnum(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_allowed(logic [2:0] mode, logic [7:0] c);
    logic base, plus, semi, colon, quest, slash;
    base  = (c == 8'h00) || (c == 8'h24) || (c == 8'h2D) || (c == 8'h5F) ||
            (c == 8'h2E) || (c == 8'h21) || (c == 8'h2A) || (c == 8'h27) ||
            (c == 8'h28) || (c == 8'h29) || (c == 8'h2C) || (c == 8'h40) ||
            (c == 8'h26) || (c == 8'h3D);
    plus  = (c == 8'h2B);
    semi  = (c == 8'h3B);
    colon = (c == 8'h3A);
    quest = (c == 8'h3F);
    slash = (c == 8'h2F);
    case (mode)
      ModePath:   return base | plus | semi | colon;
      ModeSearch: return base | semi | colon;
      ModeUser:   return base | plus | semi;
      ModeFtp:    return base | plus | quest | colon;
      default:    return base | plus | quest | slash | colon;
    endcase
  endfunction

  function automatic logic is_reserved(logic [2:0] mode, logic [7:0] c);
    return (c == 8'h00) || ((mode == ModePath) && (c == 8'h2F)) ||
           ((mode == ModeSearch) && (c == 8'h2B));
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - DigitBase;
      return {1'b1, v[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
      return {1'b1, v[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] v);
    return (v >= 4'd10) ? HexAlphaBase + {4'd0, v} : DigitBase + {4'd0, v};
  endfunction

  function automatic cmd_kind_e recode_kind(logic [2:0] mode, logic [7:0] c);
    return (is_alnum(c) || is_allowed(mode, c)) ? CmdRaw : CmdEsc;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ucenc_front.sv =====
// Front end: config registers, escape tracking, classification into commands.
// Depends on ucenc_pkg.
`default_nettype none

module ucenc_front
  import ucenc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          in_byte_i,
  input  wire logic                in_last_i,
  input  wire logic                full_i,
  output logic                     push_o,
  output cmd_t                     push_cmd_o
);

  logic [2:0]  mode_q;
  logic        decode_q;
  esc_phase_e  phase_q, phase_d;
  logic [3:0]  nib_q, nib_d;
  logic        drop_q, drop_d;
  logic        accept;
  logic [4:0]  hv;
  logic [7:0]  dec;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full_i;
  assign accept      = in_valid_i && !full_i;
  assign hv          = hex_val(in_byte_i);
  assign dec         = {nib_q, hv[3:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModePath;
      decode_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgMode:   mode_q   <= cfg_data_i;
        CfgDecode: decode_q <= cfg_data_i[0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      nib_q   <= 4'd0;
      drop_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      nib_q   <= nib_d;
      drop_q  <= drop_d;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    nib_d      = nib_q;
    drop_d     = drop_q;
    push_o     = 1'b0;
    push_cmd_o = '{kind: CmdRaw, data: in_byte_i, last: in_last_i};
    if (accept) begin
      priority if (drop_q) begin
        if (in_last_i) drop_d = 1'b0;
      end else if (phase_q == PhHigh) begin
        if (!hv[4] || in_last_i) begin
          push_o          = 1'b1;
          push_cmd_o.kind = CmdErr;
          drop_d          = !in_last_i;
          phase_d         = PhIdle;
          nib_d           = 4'd0;
        end else begin
          nib_d   = hv[3:0];
          phase_d = PhLow;
        end
      end else if (phase_q == PhLow) begin
        push_o  = 1'b1;
        phase_d = PhIdle;
        nib_d   = 4'd0;
        if (!hv[4]) begin
          push_cmd_o.kind = CmdErr;
          drop_d          = !in_last_i;
        end else begin
          push_cmd_o.data = dec;
          if (dec != 8'h00 && is_reserved(mode_q, dec)) push_cmd_o.kind = CmdEsc;
          else push_cmd_o.kind = recode_kind(mode_q, dec);
        end
      end else if (is_reserved(mode_q, in_byte_i)) begin
        push_o = 1'b1;
      end else if (decode_q && in_byte_i == Percent) begin
        if (in_last_i) begin
          push_o          = 1'b1;
          push_cmd_o.kind = CmdErr;
        end else begin
          phase_d = PhHigh;
        end
      end else begin
        push_o          = 1'b1;
        push_cmd_o.kind = recode_kind(mode_q, in_byte_i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ucenc_queue.sv =====
// Command queue between front end and back end.
// Depends on ucenc_pkg.
`default_nettype none

module ucenc_queue
  import ucenc_pkg::*;
#(
  parameter int unsigned Depth = QDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      push_cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output cmd_t      head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= bump(wr_q);
      if (pop_i) rd_q <= bump(rd_q);
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ucenc_back.sv =====
// Back end: expands commands into output bytes, one per cycle while out_ready_i allows, into an output register.
// Depends on ucenc_pkg.
`default_nettype none

module ucenc_back
  import ucenc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       empty_i,
  input  cmd_t            head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            string_last_o,
  output logic            bad_escape_o
);

  logic       busy_q, busy_d;
  cmd_t       cmd_q, cmd_d;
  logic [1:0] step_q, step_d;
  logic       ov_q, ov_d;
  logic [7:0] ob_q, ob_d;
  logic       orun_q, orun_d, ostr_q, ostr_d, obad_q, obad_d;
  cmd_t       cur;
  logic [1:0] step;
  logic       load, fin, bad;
  logic [7:0] byte_v;

  assign cur  = busy_q ? cmd_q : head_i;
  assign step = busy_q ? step_q : StepPct;
  assign load = (busy_q || !empty_i) && (!ov_q || out_ready_i);
  assign pop_o = load && !busy_q;

  always_comb begin
    byte_v = cur.data;
    fin    = 1'b1;
    bad    = 1'b0;
    unique case (cur.kind)
      CmdRaw: ;
      CmdEsc: begin
        fin = (step == StepLow);
        unique case (step)
          StepPct:  byte_v = Percent;
          StepHigh: byte_v = hex_digit(cur.data[7:4]);
          default:  byte_v = hex_digit(cur.data[3:0]);
        endcase
      end
      CmdErr: begin
        byte_v = 8'h00;
        bad    = 1'b1;
      end
      default: byte_v = 8'h00;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    cmd_d  = cmd_q;
    step_d = step_q;
    ob_d   = ob_q;
    orun_d = orun_q;
    ostr_d = ostr_q;
    obad_d = obad_q;
    ov_d   = ov_q && !out_ready_i;
    if (load) begin
      ov_d   = 1'b1;
      ob_d   = byte_v;
      orun_d = fin;
      ostr_d = fin && (cur.last || bad);
      obad_d = bad;
      busy_d = !fin;
      cmd_d  = cur;
      step_d = step + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= StepPct;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    ob_q   <= ob_d;
    orun_q <= orun_d;
    ostr_q <= ostr_d;
    obad_q <= obad_d;
  end

  assign out_valid_o   = ov_q;
  assign out_byte_o    = ob_q;
  assign run_last_o    = orun_q;
  assign string_last_o = ostr_q;
  assign bad_escape_o  = obad_q;

endmodule

`default_nettype wire

// ===== hw/rtl/url_canonical_encoder_core.sv =====
// URL component canonicalizer. Input bytes are taken one per cycle while the
// command queue has room; each yields zero, one or three output bytes. The
// output port moves one byte per cycle while m_axis_tready is high, and the
// queue lets new input bytes be taken while an escape is still written out.
// Decoding a %XX escape consumes three input bytes for one decoded byte. Input
// bytes pass through the command queue and then the output register.
// Write config only while idle.
// Depends on ucenc_pkg, ucenc_front, ucenc_queue, ucenc_back and the macros header.
`default_nettype none

`include "url_canonical_encoder_core_macros.svh"

module url_canonical_encoder_core
  import ucenc_pkg::*;
#(
  parameter int unsigned QueueDepth = QDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,  // [7:0] in_byte
  input  wire logic                s_axis_tlast,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [7:0]               m_axis_tdata,  // [7:0] out_byte
  output logic                     m_axis_tlast,
  output logic [1:0]               m_axis_tuser   // [0] run_last, [1] bad_escape
);

  logic full, empty, push, pop;
  cmd_t push_cmd, head;

  ucenc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .full_i      (full),
    .push_o      (push),
    .push_cmd_o  (push_cmd)
  );

  ucenc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  ucenc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata),
    .run_last_o    (m_axis_tuser[0]),
    .string_last_o (m_axis_tlast),
    .bad_escape_o  (m_axis_tuser[1])
  );

  `UCENC_ASSERT_IMPL(a_err_shape, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1],
    m_axis_tlast && m_axis_tuser[0] && (m_axis_tdata == 8'h00),
    "error transaction malformed")
  `UCENC_ASSERT_IMPL(a_str_in_run, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast,
    m_axis_tuser[0], "string end not at run end")
  `UCENC_ASSERT_IMPL(a_pct_opens, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata == Percent),
    !m_axis_tuser[0] && !m_axis_tuser[1], "percent not leading an escape")
  `UCENC_ASSERT(a_q_sane, clk_i, rst_ni, !(full && empty), "queue full and empty")

endmodule

`default_nettype wire
